[src/range_minimum_sparse_table_top_assert.svh]
// assertion helpers for the range minimum block
`ifndef RANGE_MINIMUM_SPARSE_TABLE_TOP_ASSERT_SVH
`define RANGE_MINIMUM_SPARSE_TABLE_TOP_ASSERT_SVH

// checked only out of reset
`define RMST_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RMST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/rmst_pkg.sv]
package rmst_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int LEVELS_DEF = 11;
    localparam int DATA_W     = 32;
    localparam int IN_IDX_W   = 10;
    localparam int LEN_W      = IN_IDX_W + 1;

    // command codes
    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [DATA_W-1:0]   value;
        logic [IN_IDX_W-1:0]        left;
        logic [IN_IDX_W-1:0]        right;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   min_value;
        logic                       range_error;
    } out_word_t;

endpackage

[src/rmst_table.sv]
module rmst_table #(
    parameter int DEPTH  = rmst_pkg::DEPTH_DEF,
    parameter int LEVELS = rmst_pkg::LEVELS_DEF
) (
    clk,
    we,
    waddr,
    wdata,
    raddr_a,
    raddr_b,
    rdata_a,
    rdata_b
);
    localparam int IW        = $clog2(DEPTH);
    localparam int LW        = $clog2(LEVELS);
    localparam int AW        = LW + IW;
    localparam int MEM_DEPTH = LEVELS << IW;

    input  logic                              clk;
    input  logic                              we;
    input  logic [AW-1:0]                     waddr;
    input  logic [rmst_pkg::DATA_W-1:0]       wdata;
    input  logic [AW-1:0]                     raddr_a;
    input  logic [AW-1:0]                     raddr_b;
    output logic [rmst_pkg::DATA_W-1:0]       rdata_a;
    output logic [rmst_pkg::DATA_W-1:0]       rdata_b;

    // level in the upper address bits, element index in the lower
    logic [rmst_pkg::DATA_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[src/rmst_cmp.sv]
module rmst_cmp (
    a,
    b,
    min_out
);
    input  logic [rmst_pkg::DATA_W-1:0] a;
    input  logic [rmst_pkg::DATA_W-1:0] b;
    output logic [rmst_pkg::DATA_W-1:0] min_out;

    // two's complement compare
    always_comb
    begin
        if ($signed(a) < $signed(b))
        begin
            min_out = a;
        end
        else
        begin
            min_out = b;
        end
    end

endmodule

[src/range_minimum_sparse_table_top.sv]
// channel  | direction | handshake                        | payload
// command  | in        | start high while busy low        | cmd (func, value, left, right)
// result   | out       | result_valid high for one cycle  | result (min_value, range_error)
//
// append: element stored in the accept cycle, then each further table level is built in turn
//   (read two blocks of the level below, write their minimum), one level at a time, as the
//   shared comparator and the one write port serve a single level build at once
// query: accept with index setup, registered table read, compare, then the result strobe;
//   a bad range answers on the next cycle; clear only zeroes the element count
// reset empties the array, table contents stay undefined; results cannot be stalled
`include "range_minimum_sparse_table_top_assert.svh"

module range_minimum_sparse_table_top #(
    parameter int DEPTH  = rmst_pkg::DEPTH_DEF,
    parameter int LEVELS = rmst_pkg::LEVELS_DEF
) (
    clk,
    rst_n,
    start,
    cmd,
    busy,
    result_valid,
    result
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = $clog2(LEVELS);
    localparam int AW = LW + IW;

    input  logic                clk;
    input  logic                rst_n;
    input  logic                start;
    input  rmst_pkg::in_word_t  cmd;
    output logic                busy;
    output logic                result_valid;
    output rmst_pkg::out_word_t result;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_AREAD = 4'b0010,
        S_AWRITE = 4'b0100,
        S_QREAD = 4'b1000
    } state_t;

    // S_QREAD is followed by a compare cycle; it reuses S_AWRITE's slot only by name below
    typedef enum logic [1:0] {
        P_APPEND = 2'b01,
        P_QUERY  = 2'b10
    } phase_t;

    state_t                      state_reg, state_next;
    phase_t                      phase_reg, phase_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               cp1_reg, cp1_next;    // appended count, c + 1
    logic [CW-1:0]               size_reg, size_next;  // block size of the level being built
    logic [LW-1:0]               level_reg, level_next;
    logic [IW-1:0]               qa_reg, qa_next;
    logic [IW-1:0]               qb_reg, qb_next;
    rmst_pkg::out_word_t         res_reg, res_next;
    logic                        res_valid_reg, res_valid_next;

    logic                        tbl_we;
    logic [AW-1:0]               tbl_waddr;
    logic [rmst_pkg::DATA_W-1:0] tbl_wdata;
    logic [AW-1:0]               tbl_raddr_a;
    logic [AW-1:0]               tbl_raddr_b;
    logic [rmst_pkg::DATA_W-1:0] tbl_rdata_a;
    logic [rmst_pkg::DATA_W-1:0] tbl_rdata_b;
    logic [rmst_pkg::DATA_W-1:0] min_val;

    logic                        accept;
    logic [CW-1:0]               blk_start;
    logic [CW-1:0]               blk_mid;
    logic                        full;
    logic                        q_err;
    logic [rmst_pkg::LEN_W-1:0]  q_len;
    logic [3:0]                  q_msb;
    logic [LW-1:0]               q_k;
    logic [rmst_pkg::LEN_W-1:0]  q_second;
    logic [CW:0]                 size_dbl;

    rmst_table #(
        .DEPTH  (DEPTH),
        .LEVELS (LEVELS)
    ) u_table (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   (tbl_wdata),
        .raddr_a (tbl_raddr_a),
        .raddr_b (tbl_raddr_b),
        .rdata_a (tbl_rdata_a),
        .rdata_b (tbl_rdata_b)
    );

    // the one comparator, shared by table build and query
    rmst_cmp u_cmp (
        .a       (tbl_rdata_a),
        .b       (tbl_rdata_b),
        .min_out (min_val)
    );

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign full         = (count_reg == CW'(DEPTH));

    // level j block that ends at the new element starts at c + 1 - 2^j
    assign blk_start = cp1_reg - size_reg;
    assign blk_mid   = blk_start + (size_reg >> 1);
    assign size_dbl  = {size_reg, 1'b0};

    // query decode: range check, floor(log2(len)) capped to the top level
    always_comb
    begin
        q_err = (cmd.left > cmd.right)
             || (32'(cmd.right) >= 32'(count_reg));
        q_len = {1'b0, cmd.right} - {1'b0, cmd.left} + rmst_pkg::LEN_W'(1);
        q_msb = 4'd0;
        for (int i = 0; i < rmst_pkg::LEN_W; i++)
        begin
            if (q_len[i])
            begin
                q_msb = 4'(i);
            end
        end
        if (int'(q_msb) > LEVELS - 1)
        begin
            q_k = LW'(LEVELS - 1);
        end
        else
        begin
            q_k = LW'(q_msb);
        end
        q_second = {1'b0, cmd.right} + rmst_pkg::LEN_W'(1)
                 - (rmst_pkg::LEN_W'(1) << q_k);
    end

    // table ports
    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = {level_reg, blk_start[IW-1:0]};
        tbl_wdata = min_val;
        if (phase_reg == P_QUERY)
        begin
            tbl_raddr_a = {level_reg, qa_reg};
            tbl_raddr_b = {level_reg, qb_reg};
        end
        else
        begin
            tbl_raddr_a = {level_reg - LW'(1), blk_start[IW-1:0]};
            tbl_raddr_b = {level_reg - LW'(1), blk_mid[IW-1:0]};
        end
        if (accept && cmd.func == rmst_pkg::FUNC_APPEND && !full)
        begin
            // level 0 holds the element itself
            tbl_we    = 1'b1;
            tbl_waddr = {LW'(0), count_reg[IW-1:0]};
            tbl_wdata = cmd.value;
        end
        else if (state_reg == S_AWRITE && phase_reg == P_APPEND)
        begin
            tbl_we = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        cp1_next       = cp1_reg;
        size_next      = size_reg;
        level_next     = level_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == rmst_pkg::FUNC_APPEND && !full)
                    begin
                        count_next = count_reg + CW'(1);
                        cp1_next   = count_reg + CW'(1);
                        size_next  = CW'(2);
                        level_next = LW'(1);
                        phase_next = P_APPEND;
                        if (count_reg != '0)
                        begin
                            state_next = S_AREAD;
                        end
                    end
                    else if (cmd.func == rmst_pkg::FUNC_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (cmd.func == rmst_pkg::FUNC_QUERY)
                    begin
                        if (q_err)
                        begin
                            res_next.min_value   = '0;
                            res_next.range_error = 1'b1;
                            res_valid_next       = 1'b1;
                        end
                        else
                        begin
                            qa_next    = IW'(cmd.left);
                            qb_next    = IW'(q_second);
                            level_next = q_k;
                            phase_next = P_QUERY;
                            state_next = S_QREAD;
                        end
                    end
                end
            end
            S_AREAD:
            begin
                state_next = S_AWRITE;
            end
            S_QREAD:
            begin
                // read data lands in the compare cycle
                state_next = S_AWRITE;
            end
            S_AWRITE:
            begin
                if (phase_reg == P_QUERY)
                begin
                    res_next.min_value   = min_val;
                    res_next.range_error = 1'b0;
                    res_valid_next       = 1'b1;
                    phase_next           = P_APPEND;
                    state_next           = S_IDLE;
                end
                else if (level_reg != LW'(LEVELS - 1) && size_dbl <= {1'b0, cp1_reg})
                begin
                    size_next  = size_dbl[CW-1:0];
                    level_next = level_reg + LW'(1);
                    state_next = S_AREAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_APPEND;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp1_reg   <= cp1_next;
        size_reg  <= size_next;
        level_reg <= level_next;
        qa_reg    <= qa_next;
        qb_reg    <= qb_next;
        res_reg   <= res_next;
    end

    // stored count never passes the array depth
    `RMST_ASSERT_RST(a_count_bound, count_reg <= CW'(DEPTH), "element count past depth")
    // an error answer carries a zero value
    `RMST_ASSERT_RST(a_err_zero,
        res_valid_reg && res_reg.range_error |-> res_reg.min_value == '0,
        "error result with nonzero value")
    // a query compare cycle always ends in a good answer
    `RMST_ASSERT_RST(a_query_answer,
        state_reg == S_AWRITE && phase_reg == P_QUERY |=> res_valid_reg && !res_reg.range_error,
        "query compare gave no answer")
    // no element is written while the array is full
    `RMST_ASSERT_RST(a_no_write_full, tbl_we && state_reg == S_IDLE |-> !full, "table written while full")

endmodule

[tb/range_minimum_sparse_table_top_tb.sv]
module range_minimum_sparse_table_top_tb;
    import rmst_pkg::*;

    localparam int TABLE_DEPTH = DEPTH_DEF;
    localparam int TABLE_LEVELS = LEVELS_DEF;
    // quiet tail, with room on top of the longest append
    localparam int TAIL_CYCLES = 4 * LEVELS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 40;
    // spare command code, the block must ignore it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // one queued command word plus the idle gap the driver leaves before it
    typedef struct {
        in_word_t word;
        int       gap;
    } pending_word_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  cmd = '0;
    logic      busy;
    logic      result_valid;
    out_word_t result;

    range_minimum_sparse_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the sparse table
    // level j, entry i holds the minimum of elements i .. i + 2^j - 1
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] block_min [TABLE_LEVELS][TABLE_DEPTH];
    int unsigned              stored_count = 0;
    out_word_t                pending_answers [$];

    // run statistics for the summary
    int unsigned n_appends = 0;
    int unsigned n_dropped = 0;
    int unsigned n_queries = 0;
    int unsigned n_bad_ranges = 0;
    int unsigned n_clears = 0;
    int unsigned n_unused = 0;
    int unsigned peak_count = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    function automatic logic signed [DATA_W-1:0] lesser_of(logic signed [DATA_W-1:0] a,
                                                           logic signed [DATA_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // append one element and refresh every level whose block ends on it
    function automatic void store_element(logic signed [DATA_W-1:0] v);
        int unsigned c;
        int unsigned span;
        int unsigned first;
        int          lvl;
        c = stored_count;
        if (c >= TABLE_DEPTH)
        begin
            n_dropped++;
            return;
        end
        block_min[0][c] = v;
        for (lvl = 1; lvl < TABLE_LEVELS; lvl++)
        begin
            span = 1 << lvl;
            if (span > c + 1)
                break;
            first = c + 1 - span;
            block_min[lvl][first] = lesser_of(block_min[lvl-1][first],
                                              block_min[lvl-1][first + span/2]);
        end
        stored_count = c + 1;
        if (stored_count > peak_count)
            peak_count = stored_count;
    endfunction

    // minimum over [lo, hi] from two overlapping power-of-two blocks
    function automatic out_word_t range_answer(int unsigned lo, int unsigned hi);
        out_word_t   ans;
        int unsigned len;
        int unsigned k;
        int unsigned span;
        ans = '0;
        if (lo > hi || hi >= stored_count)
        begin
            ans.range_error = 1'b1;
            n_bad_ranges++;
            return ans;
        end
        len = hi - lo + 1;
        k = 0;
        while ((len >> (k + 1)) != 0)
            k++;
        if (k > TABLE_LEVELS - 1)
            k = TABLE_LEVELS - 1;
        span = 1 << k;
        ans.min_value = lesser_of(block_min[k][lo], block_min[k][hi + 1 - span]);
        return ans;
    endfunction

    // effect of one accepted command word on the shadow state
    function automatic void apply_word(in_word_t w);
        case (w.func)
            FUNC_APPEND:
            begin
                n_appends++;
                store_element(w.value);
            end
            FUNC_QUERY:
            begin
                n_queries++;
                pending_answers.push_back(range_answer(w.left, w.right));
            end
            FUNC_CLEAR:
            begin
                n_clears++;
                stored_count = 0;
            end
            default:
                n_unused++;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // monitor: check results, then fold the word taken at this edge into
    // the shadow state; a result never belongs to the word taken with it
    // ------------------------------------------------------------------
    logic      word_taken = 1'b0;
    out_word_t wanted;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch($sformatf("result %0d/%0b with no query waiting",
                                              result.min_value, result.range_error));
                else
                begin
                    wanted = pending_answers.pop_front();
                    if (result.min_value !== wanted.min_value)
                        report_mismatch($sformatf("min_value %0d, expected %0d",
                                                  result.min_value, wanted.min_value));
                    if (result.range_error !== wanted.range_error)
                        report_mismatch($sformatf("range_error %b, expected %b",
                                                  result.range_error, wanted.range_error));
                end
            end
            word_taken <= start && !busy;
            if (start && !busy)
                apply_word(cmd);
        end
    end

    // ------------------------------------------------------------------
    // driver: falling edge, holds a word until taken, then idles for the
    // gap drawn for the next word; a gap of zero keeps start high
    // ------------------------------------------------------------------
    pending_word_t pending_words [$];
    int            idle_cycles = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(start && !word_taken))
        begin
            if (start)
                idle_cycles = 0;
            if (pending_words.size() != 0 && idle_cycles >= pending_words[0].gap)
            begin
                start <= 1'b1;
                cmd <= pending_words[0].word;
                void'(pending_words.pop_front());
                idle_cycles = 0;
            end
            else
            begin
                start <= 1'b0;
                // junk on the bus while idle, must be ignored
                cmd <= in_word_t'({$urandom, $urandom});
                idle_cycles++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("range_minimum_sparse_table_top_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    bit          calm = 1'b0;
    int unsigned planned_count = 0;
    int unsigned words_queued = 0;

    task automatic queue_word(logic [1:0] f, logic signed [DATA_W-1:0] v,
                              int unsigned l, int unsigned r);
        pending_word_t p;
        p.word.func = f;
        p.word.value = v;
        p.word.left = l[IN_IDX_W-1:0];
        p.word.right = r[IN_IDX_W-1:0];
        p.gap = calm ? 0 : $urandom_range(0, 5);
        pending_words.push_back(p);
        words_queued++;
        // track the element count so that queries can be aimed
        if (f == FUNC_APPEND && planned_count < TABLE_DEPTH)
            planned_count++;
        else if (f == FUNC_CLEAR)
            planned_count = 0;
    endtask

    // mostly full-range values, with clusters of small ones and the extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2, 3, 4:
            begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_good_query();
        int unsigned n;
        int unsigned hi;
        int unsigned lo;
        n = planned_count;
        if (n == 0)
        begin
            // nothing stored, any range is out of bounds
            queue_word(FUNC_QUERY, $urandom, 0, $urandom_range(0, TABLE_DEPTH - 1));
            return;
        end
        hi = $urandom_range(0, n - 1);
        case ($urandom_range(0, 3))
            0: lo = hi;
            1: lo = hi - $urandom_range(0, (hi < 8) ? hi : 8);
            2: lo = 0;
            default: lo = $urandom_range(0, hi);
        endcase
        queue_word(FUNC_QUERY, $urandom, lo, hi);
    endtask

    task automatic queue_bad_query();
        int unsigned hi;
        int unsigned lo;
        if (planned_count < TABLE_DEPTH && $urandom_range(0, 1) == 0)
        begin
            // right end at or past the element count
            hi = $urandom_range(planned_count, TABLE_DEPTH - 1);
            lo = $urandom_range(0, hi);
        end
        else
        begin
            // reversed range
            lo = $urandom_range(1, TABLE_DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
        end
        queue_word(FUNC_QUERY, $urandom, lo, hi);
    endtask

    initial
    begin
        int unsigned i;
        int unsigned pick;
        int unsigned fill;
        int unsigned len;
        int unsigned lo;
        int          lvl;

        // directed part: extremes, every code, the corner cases
        queue_word(FUNC_QUERY, 32'sh0, 0, 0);                  // query on an empty array
        queue_word(FUNC_APPEND, 32'sh7FFF_FFFF, 1023, 1023);
        queue_word(FUNC_QUERY, 32'sh0, 0, 0);                  // single most positive
        queue_word(FUNC_APPEND, 32'sh8000_0000, 0, 0);
        queue_word(FUNC_APPEND, 32'sh0, 0, 0);
        queue_word(FUNC_APPEND, -32'sd1, 0, 0);
        queue_word(FUNC_APPEND, 32'sd1, 0, 0);
        queue_word(FUNC_QUERY, 32'sh0, 0, 4);                  // whole array, most negative
        queue_word(FUNC_QUERY, 32'sh0, 1, 1);
        queue_word(FUNC_QUERY, -32'sd1, 2, 4);
        queue_word(FUNC_QUERY, 32'sh0, 4, 4);
        queue_word(FUNC_QUERY, 32'sh0, 3, 2);                  // reversed
        queue_word(FUNC_QUERY, 32'sh0, 0, 5);                  // right equals the count
        queue_word(FUNC_QUERY, 32'sh0, 1023, 1023);            // far past the count
        queue_word(FUNC_QUERY, -32'sd1, 1023, 0);              // reversed, all index bits
        queue_word(FUNC_UNUSED, -32'sd1, 1023, 1023);          // spare code, no effect
        queue_word(FUNC_QUERY, 32'sh0, 0, 1);
        queue_word(FUNC_QUERY, 32'sh0, 0, 5);                  // count unchanged by spare code
        queue_word(FUNC_CLEAR, -32'sd1, 1023, 1023);
        queue_word(FUNC_QUERY, 32'sh0, 0, 0);                  // empty again after clear
        queue_word(FUNC_APPEND, 32'sd5, 0, 0);
        queue_word(FUNC_APPEND, 32'sd5, 0, 0);                 // equal neighbors
        queue_word(FUNC_QUERY, 32'sh0, 0, 1);
        queue_word(FUNC_QUERY, 32'sh0, 1, 1);

        // short episodes: usually a clear, a run of appends, then mostly aimed queries
        while (words_queued < 100)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
                queue_word(FUNC_CLEAR, $urandom, $urandom, $urandom);
            fill = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
            repeat (fill)
                queue_word(FUNC_APPEND, pick_value(), $urandom, $urandom);
            repeat ($urandom_range(8, 30))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    queue_good_query();
                else if (pick < 78)
                    queue_bad_query();
                else if (pick < 95)
                    queue_word(FUNC_APPEND, pick_value(), $urandom, $urandom);
                else if (pick < 98)
                    queue_word(FUNC_UNUSED, $urandom, $urandom, $urandom);
                else
                    queue_word(FUNC_CLEAR, $urandom, $urandom, $urandom);
            end
        end

        // one fill to the top, a few appends past full, queries sprinkled in
        queue_word(FUNC_CLEAR, $urandom, $urandom, $urandom);
        for (i = 0; i < TABLE_DEPTH + 8; i++)
        begin
            if (i % 128 == 0)
                calm = ($urandom_range(0, 2) == 0);
            queue_word(FUNC_APPEND, pick_value(), $urandom, $urandom);
            if ($urandom_range(0, 15) == 0)
                queue_good_query();
        end
        calm = 1'b0;
        queue_word(FUNC_QUERY, $urandom, 0, TABLE_DEPTH - 1);
        queue_word(FUNC_QUERY, $urandom, TABLE_DEPTH - 1, TABLE_DEPTH - 1);
        // every block level, plus lengths just off a power of two
        for (lvl = 0; lvl < TABLE_LEVELS; lvl++)
        begin
            len = 1 << lvl;
            lo = $urandom_range(0, TABLE_DEPTH - len);
            queue_word(FUNC_QUERY, $urandom, lo, lo + len - 1);
            if (len > 1)
                queue_word(FUNC_QUERY, $urandom, lo, lo + len - 2);
            if (len < TABLE_DEPTH)
            begin
                lo = $urandom_range(0, TABLE_DEPTH - len - 1);
                queue_word(FUNC_QUERY, $urandom, lo, lo + len);
            end
        end
        repeat (80)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                queue_good_query();
            else if (pick < 92)
                queue_bad_query();
            else if (pick < 96)
                queue_word(FUNC_APPEND, pick_value(), $urandom, $urandom);
            else
                queue_word(FUNC_UNUSED, $urandom, $urandom, $urandom);
        end
        queue_word(FUNC_CLEAR, $urandom, $urandom, $urandom);
        queue_word(FUNC_QUERY, $urandom, 0, 0);

        // reset, released on a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: every word taken, every answer back, then a quiet tail
        @(posedge clk);
        while (pending_words.size() != 0 || start || pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d appends (%0d on a full array), %0d queries (%0d bad ranges)",
                 n_appends, n_dropped, n_queries, n_bad_ranges);
        $display("%0d clears, %0d spare codes, peak of %0d elements, %0d cycles",
                 n_clears, n_unused, peak_count, cycle_count);
        if (mismatches == 0)
            $display("range_minimum_sparse_table_top_tb passed");
        else
            $display("range_minimum_sparse_table_top_tb failed");
        $finish;
    end

endmodule
